### rtl/core/euler_zyx_to_rotation_matrix_unit_macros.svh
// Assertion macros of the rotation matrix unit checker.
`ifndef EULER_ZYX_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define EULER_ZYX_TO_ROTATION_MATRIX_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define EUZYX_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, also checked while reset is asserted.
`define EUZYX_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) ante |=> cons) else $error(msg);

`endif

### rtl/core/euzyx_pkg.sv
// Shared constants, payload types and arithmetic helpers of the rotation matrix unit.
package euzyx_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int ENTRY_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    // internal fixed point: Q30 in 32-bit lanes
    localparam int QF        = 30;
    localparam int VAL_W     = QF + 2;
    localparam int ANG_W     = QF + 3;
    localparam int ANG_SHIFT = QF - (ANGLE_BITS - 3);
    localparam int SUM_W     = VAL_W + 1;

    localparam int FE       = ENTRY_BITS - 2;
    localparam int ROUND_SH = QF - FE;

    localparam int LANE_STAGES  = CORDIC_STEPS + 2;
    localparam int MERGE_STAGES = 4;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    localparam logic signed [ANG_W-1:0] PI_Q      = 33'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 33'sd1686629713;
    localparam logic signed [VAL_W-1:0] GAIN_Q    = 32'sd652032874;

    localparam logic signed [2*VAL_W-1:0] RMUL_HALF  = 64'sd1 <<< (QF - 1);
    localparam logic signed [SUM_W:0]     RND_HALF   = (SUM_W + 1)'((longint'(1) << ROUND_SH) >> 1);
    localparam logic signed [SUM_W:0]     ENTRY_ONE  = (SUM_W + 1)'(longint'(1) << FE);

    localparam logic signed [VAL_W-1:0] ATAN_Q [32] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
        32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
        32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
        32'sd1023,      32'sd511,       32'sd255,       32'sd127,
        32'sd63,        32'sd31,        32'sd15,        32'sd7,
        32'sd3,         32'sd1,         32'sd0,         32'sd0
    };

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_in_req;

    typedef struct packed {
        logic signed [ENTRY_BITS-1:0] r_xx;
        logic signed [ENTRY_BITS-1:0] r_xy;
        logic signed [ENTRY_BITS-1:0] r_xz;
        logic signed [ENTRY_BITS-1:0] r_yx;
        logic signed [ENTRY_BITS-1:0] r_yy;
        logic signed [ENTRY_BITS-1:0] r_yz;
        logic signed [ENTRY_BITS-1:0] r_zx;
        logic signed [ENTRY_BITS-1:0] r_zy;
        logic signed [ENTRY_BITS-1:0] r_zz;
    } t_out_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] cos_v;
        logic signed [VAL_W-1:0] sin_v;
    } t_cs;

    // Q30 product, rounded half up
    function automatic logic signed [VAL_W-1:0] rmul(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [2*VAL_W-1:0] p;
        p = a * b;
        p = p + RMUL_HALF;
        return VAL_W'(p >>> QF);
    endfunction

    // Q30 sum to output format: round to nearest, clamp to plus or minus one
    function automatic logic signed [ENTRY_BITS-1:0] to_entry(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W:0] r;
        r = (SUM_W + 1)'(v) + RND_HALF;
        r = r >>> ROUND_SH;
        if (r > ENTRY_ONE) begin
            r = ENTRY_ONE;
        end else if (r < -ENTRY_ONE) begin
            r = -ENTRY_ONE;
        end
        return ENTRY_BITS'(r);
    endfunction

endpackage

### rtl/core/euler_zyx_to_rotation_matrix_unit.sv
// Throughput: one request per clock cycle while the output is not stalled. The pipeline is
// formed by the three CORDIC lanes, which run one iteration per pipeline stage, followed by the
// four-stage product, sum and rounding merge. Each stage keeps its own valid bit and moves
// whenever the stage after it is empty or moving, so a stalled result only holds the
// requests queued directly behind it; empty stages further up keep taking new requests.
module euler_zyx_to_rotation_matrix_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  euzyx_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output euzyx_pkg::t_out_req o_out_req
);
    import euzyx_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] w_en;
    t_cs                    w_roll_cs;
    t_cs                    w_pitch_cs;
    t_cs                    w_yaw_cs;

    // a stage advances when it is empty or the stage after it advances
    always_comb begin
        w_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld = {r_vld[PIPE_STAGES-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    euzyx_cordic_lane u_roll_lane (
        .i_clk   (i_clk),
        .i_angle (i_in_req.roll_angle),
        .i_en    (w_en[LANE_STAGES-1:0]),
        .o_cs    (w_roll_cs)
    );

    euzyx_cordic_lane u_pitch_lane (
        .i_clk   (i_clk),
        .i_angle (i_in_req.pitch_angle),
        .i_en    (w_en[LANE_STAGES-1:0]),
        .o_cs    (w_pitch_cs)
    );

    euzyx_cordic_lane u_yaw_lane (
        .i_clk   (i_clk),
        .i_angle (i_in_req.yaw_angle),
        .i_en    (w_en[LANE_STAGES-1:0]),
        .o_cs    (w_yaw_cs)
    );

    euzyx_merge u_merge (
        .i_clk   (i_clk),
        .i_roll  (w_roll_cs),
        .i_pitch (w_pitch_cs),
        .i_yaw   (w_yaw_cs),
        .i_en    (w_en[PIPE_STAGES-1:LANE_STAGES]),
        .o_res   (o_out_req)
    );

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[PIPE_STAGES-1];

endmodule

### rtl/core/euzyx_cordic_lane.sv
// One angle lane: range reduction, pipelined rotation-mode CORDIC, quadrant fix-up.
module euzyx_cordic_lane (
    input  logic                                   i_clk,
    input  logic signed [euzyx_pkg::ANGLE_BITS-1:0] i_angle,
    input  logic [euzyx_pkg::LANE_STAGES-1:0]       i_en,
    output euzyx_pkg::t_cs                          o_cs
);
    import euzyx_pkg::*;

    logic signed [VAL_W-1:0] r_x    [CORDIC_STEPS+1];
    logic signed [VAL_W-1:0] r_y    [CORDIC_STEPS+1];
    logic signed [VAL_W-1:0] r_z    [CORDIC_STEPS+1];
    logic                    r_flip [CORDIC_STEPS+1];
    t_cs                     r_cs;

    logic signed [ANG_W-1:0] w_z_full;
    logic signed [ANG_W-1:0] n_z_red;
    logic                    n_flip;

    // fold the angle into [-pi/2, pi/2]; the fold negates cosine and sine
    always_comb begin
        w_z_full = ANG_W'(i_angle) <<< ANG_SHIFT;
        n_z_red  = w_z_full;
        n_flip   = 1'b0;
        if (w_z_full > HALF_PI_Q) begin
            n_z_red = w_z_full - PI_Q;
            n_flip  = 1'b1;
        end else if (w_z_full < -HALF_PI_Q) begin
            n_z_red = w_z_full + PI_Q;
            n_flip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= GAIN_Q;
            r_y[0]    <= '0;
            r_z[0]    <= VAL_W'(n_z_red);
            r_flip[0] <= n_flip;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
        localparam int I = k - 1;
        logic signed [VAL_W-1:0] w_xs;
        logic signed [VAL_W-1:0] w_ys;

        assign w_xs = r_x[k-1] >>> I;
        assign w_ys = r_y[k-1] >>> I;

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_flip[k] <= r_flip[k-1];
                if (!r_z[k-1][VAL_W-1]) begin
                    r_x[k] <= r_x[k-1] - w_ys;
                    r_y[k] <= r_y[k-1] + w_xs;
                    r_z[k] <= r_z[k-1] - ATAN_Q[I];
                end else begin
                    r_x[k] <= r_x[k-1] + w_ys;
                    r_y[k] <= r_y[k-1] - w_xs;
                    r_z[k] <= r_z[k-1] + ATAN_Q[I];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[LANE_STAGES-1]) begin
            if (r_flip[CORDIC_STEPS]) begin
                r_cs.cos_v <= -r_x[CORDIC_STEPS];
                r_cs.sin_v <= -r_y[CORDIC_STEPS];
            end else begin
                r_cs.cos_v <= r_x[CORDIC_STEPS];
                r_cs.sin_v <= r_y[CORDIC_STEPS];
            end
        end
    end

    assign o_cs = r_cs;

endmodule

### rtl/core/euzyx_merge.sv
// Combines the three lanes' cosines and sines into the nine rounded, saturated entries.
module euzyx_merge (
    input  logic                               i_clk,
    input  euzyx_pkg::t_cs                     i_roll,
    input  euzyx_pkg::t_cs                     i_pitch,
    input  euzyx_pkg::t_cs                     i_yaw,
    input  logic [euzyx_pkg::MERGE_STAGES-1:0] i_en,
    output euzyx_pkg::t_out_req                o_res
);
    import euzyx_pkg::*;

    // first products and pass-through sines
    logic signed [VAL_W-1:0] r_cycp, r_cysp, r_crsy, r_sysr, r_cycr;
    logic signed [VAL_W-1:0] r_cpsy, r_sysp, r_cysr, r_cpsr, r_cpcr;
    logic signed [VAL_W-1:0] r_sr1, r_sp1;

    // triple products and pass-through terms
    logic signed [VAL_W-1:0] r_t1, r_t2, r_t3, r_t4;
    logic signed [VAL_W-1:0] r_cycp2, r_crsy2, r_sysr2, r_cycr2;
    logic signed [VAL_W-1:0] r_cpsy2, r_cysr2, r_cpsr2, r_cpcr2, r_sp2;

    logic signed [SUM_W-1:0] r_m [9];
    t_out_req                r_res;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cycp <= rmul(i_yaw.cos_v, i_pitch.cos_v);
            r_cysp <= rmul(i_yaw.cos_v, i_pitch.sin_v);
            r_crsy <= rmul(i_roll.cos_v, i_yaw.sin_v);
            r_sysr <= rmul(i_yaw.sin_v, i_roll.sin_v);
            r_cycr <= rmul(i_yaw.cos_v, i_roll.cos_v);
            r_cpsy <= rmul(i_pitch.cos_v, i_yaw.sin_v);
            r_sysp <= rmul(i_yaw.sin_v, i_pitch.sin_v);
            r_cysr <= rmul(i_yaw.cos_v, i_roll.sin_v);
            r_cpsr <= rmul(i_pitch.cos_v, i_roll.sin_v);
            r_cpcr <= rmul(i_pitch.cos_v, i_roll.cos_v);
            r_sr1  <= i_roll.sin_v;
            r_sp1  <= i_pitch.sin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t1    <= rmul(r_cysp, r_sr1);
            r_t2    <= rmul(r_cycr, r_sp1);
            r_t3    <= rmul(r_sysp, r_sr1);
            r_t4    <= rmul(r_crsy, r_sp1);
            r_cycp2 <= r_cycp;
            r_crsy2 <= r_crsy;
            r_sysr2 <= r_sysr;
            r_cycr2 <= r_cycr;
            r_cpsy2 <= r_cpsy;
            r_cysr2 <= r_cysr;
            r_cpsr2 <= r_cpsr;
            r_cpcr2 <= r_cpcr;
            r_sp2   <= r_sp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m[0] <= SUM_W'(r_cycp2);
            r_m[1] <= SUM_W'(r_t1) - SUM_W'(r_crsy2);
            r_m[2] <= SUM_W'(r_sysr2) + SUM_W'(r_t2);
            r_m[3] <= SUM_W'(r_cpsy2);
            r_m[4] <= SUM_W'(r_cycr2) + SUM_W'(r_t3);
            r_m[5] <= SUM_W'(r_t4) - SUM_W'(r_cysr2);
            r_m[6] <= -SUM_W'(r_sp2);
            r_m[7] <= SUM_W'(r_cpsr2);
            r_m[8] <= SUM_W'(r_cpcr2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_res.r_xx <= to_entry(r_m[0]);
            r_res.r_xy <= to_entry(r_m[1]);
            r_res.r_xz <= to_entry(r_m[2]);
            r_res.r_yx <= to_entry(r_m[3]);
            r_res.r_yy <= to_entry(r_m[4]);
            r_res.r_yz <= to_entry(r_m[5]);
            r_res.r_zx <= to_entry(r_m[6]);
            r_res.r_zy <= to_entry(r_m[7]);
            r_res.r_zz <= to_entry(r_m[8]);
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/euzyx_checker.sv
// Port-level checks of the rotation matrix unit, bound to its top level.
`include "euler_zyx_to_rotation_matrix_unit_macros.svh"

module euzyx_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input euzyx_pkg::t_in_req  i_in_req,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input euzyx_pkg::t_out_req o_out_req
);
    import euzyx_pkg::*;

    logic w_in_range;
    logic w_in_seen;

    // every entry stays within plus or minus one after saturation
    always_comb begin
        w_in_range =
            ((SUM_W + 1)'(o_out_req.r_xx) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_xx) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_xy) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_xy) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_xz) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_xz) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_yx) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_yx) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_yy) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_yy) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_yz) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_yz) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_zx) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_zx) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_zy) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_zy) >= -ENTRY_ONE) &&
            ((SUM_W + 1)'(o_out_req.r_zz) <= ENTRY_ONE) && ((SUM_W + 1)'(o_out_req.r_zz) >= -ENTRY_ONE);
        w_in_seen = i_in_valid && (i_in_req == i_in_req);
    end

    `EUZYX_ASSERT_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid, "result valid right after reset")
    `EUZYX_ASSERT_ALWAYS(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "request refused with empty output")
    `EUZYX_ASSERT_ALWAYS(a_entry_range, i_clk, i_rst_n, o_out_valid |-> w_in_range, "matrix entry beyond plus or minus one")
    `EUZYX_ASSERT_ALWAYS(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req), "stalled result dropped or changed")
    `EUZYX_ASSERT_ALWAYS(a_no_early_out, i_clk, i_rst_n, $past(!i_rst_n) && !w_in_seen |=> !o_out_valid, "result without any request after reset")

endmodule

bind euler_zyx_to_rotation_matrix_unit euzyx_checker u_euzyx_checker (.*);

### verif/tb_euler_zyx_to_rotation_matrix_unit.sv
// Self-checking testbench of the z-y-x Euler angle to rotation matrix unit.
module tb_euler_zyx_to_rotation_matrix_unit;

    localparam int ANGLE_W        = euzyx_pkg::ANGLE_BITS;
    localparam int ENTRY_W        = euzyx_pkg::ENTRY_BITS;
    localparam int STEPS          = euzyx_pkg::CORDIC_STEPS;
    localparam int LATENCY        = STEPS + 6;
    localparam int NUM_ENTRIES    = 9;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 100;
    localparam int CALM_FIRST     = 800;
    localparam int CALM_LAST      = 1400;

    // internal fixed point of the angle pipeline
    localparam int     FRAC          = 30;
    localparam int     WIDEN_SHIFT   = FRAC - (ANGLE_W - 3);
    localparam int     ENTRY_FRAC    = ENTRY_W - 2;
    localparam int     ENTRY_SHIFT   = FRAC - ENTRY_FRAC;
    localparam longint ANGLE_PI      = 64'sd3373259426;
    localparam longint ANGLE_HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_GAIN   = 64'sd652032874;
    localparam longint ENTRY_ONE     = longint'(1) << ENTRY_FRAC;

    localparam longint ATAN_STEP [32] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127,
        63,        31,        15,        7,
        3,         1,         0,         0
    };

    typedef struct packed {
        euzyx_pkg::t_in_req  angles;
        logic                fixed_want;
        euzyx_pkg::t_out_req want;
    } t_angle_row;

    localparam logic signed [ENTRY_W-1:0] E1 = 16'sd16384;
    localparam logic signed [ENTRY_W-1:0] E0 = 16'sd0;
    localparam euzyx_pkg::t_out_req IDENTITY = '{E1, E0, E0, E0, E1, E0, E0, E0, E1};
    localparam euzyx_pkg::t_out_req NONE     = '0;

    localparam int NUM_DIRECTED = 22;
    localparam t_angle_row DIRECTED [NUM_DIRECTED] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, IDENTITY},
        '{'{16'sd32767, 16'sd0, 16'sd0}, 1'b0, NONE},
        '{'{16'h8000, 16'sd0, 16'sd0}, 1'b0, NONE},
        '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b0, NONE},
        '{'{16'sd0, 16'h8000, 16'sd0}, 1'b0, NONE},
        '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b0, NONE},
        '{'{16'sd0, 16'sd0, 16'h8000}, 1'b0, NONE},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, NONE},
        '{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, NONE},
        '{'{16'sd12867, 16'sd12867, 16'sd12867}, 1'b0, NONE},
        '{'{16'sd12868, 16'sd12868, 16'sd12868}, 1'b0, NONE},
        '{'{-16'sd12867, -16'sd12867, -16'sd12867}, 1'b0, NONE},
        '{'{-16'sd12868, -16'sd12868, -16'sd12868}, 1'b0, NONE},
        '{'{16'sd12868, -16'sd12868, 16'sd12867}, 1'b0, NONE},
        '{'{16'sd25736, 16'sd25736, 16'sd25736}, 1'b0, NONE},
        '{'{-16'sd25736, -16'sd25736, -16'sd25736}, 1'b0, NONE},
        '{'{16'sd1, -16'sd1, 16'sd1}, 1'b0, NONE},
        '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, NONE},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, NONE},
        '{'{16'sd0, 16'sd12868, 16'sd0}, 1'b0, NONE},
        '{'{16'sd6434, 16'sd6434, 16'sd6434}, 1'b0, NONE},
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, IDENTITY}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    euzyx_pkg::t_in_req  i_in_req    = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    euzyx_pkg::t_out_req o_out_req;

    euzyx_pkg::t_out_req matrix_q [$];
    string               entry_name [NUM_ENTRIES] = '{
        "r_xx", "r_xy", "r_xz", "r_yx", "r_yy", "r_yz", "r_zx", "r_zy", "r_zz"
    };
    int                  err_cnt      = 0;
    int                  results_seen = 0;
    int                  cycle_cnt    = 0;
    int                  quiet_cnt    = 0;

    euler_zyx_to_rotation_matrix_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] q30_to_entry(input longint v);
        longint r;
        r = (v + (longint'(1) << (ENTRY_SHIFT - 1))) >>> ENTRY_SHIFT;
        if (r > ENTRY_ONE) begin
            r = ENTRY_ONE;
        end else if (r < -ENTRY_ONE) begin
            r = -ENTRY_ONE;
        end
        return ENTRY_W'(r);
    endfunction

    function automatic void cordic_cos_sin(input logic signed [ANGLE_W-1:0] angle,
                                           output longint cos_v, output longint sin_v);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z    = longint'(angle) * (longint'(1) << WIDEN_SHIFT);
        x    = CORDIC_GAIN;
        y    = 0;
        flip = 1'b0;
        // fold into +-pi/2; the half turn negates both outputs
        if (z > ANGLE_HALF_PI) begin
            z    = z - ANGLE_PI;
            flip = 1'b1;
        end else if (z < -ANGLE_HALF_PI) begin
            z    = z + ANGLE_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end
            x = nx;
        end
        cos_v = flip ? -x : x;
        sin_v = flip ? -y : y;
    endfunction

    function automatic euzyx_pkg::t_out_req predict_matrix(input euzyx_pkg::t_in_req a);
        longint cr, sr, cp, sp, cy, sy;
        euzyx_pkg::t_out_req m;
        cordic_cos_sin(a.roll_angle, cr, sr);
        cordic_cos_sin(a.pitch_angle, cp, sp);
        cordic_cos_sin(a.yaw_angle, cy, sy);
        m.r_xx = q30_to_entry(round_mul(cy, cp));
        m.r_xy = q30_to_entry(round_mul(round_mul(cy, sp), sr) - round_mul(cr, sy));
        m.r_xz = q30_to_entry(round_mul(sy, sr) + round_mul(round_mul(cy, cr), sp));
        m.r_yx = q30_to_entry(round_mul(cp, sy));
        m.r_yy = q30_to_entry(round_mul(cy, cr) + round_mul(round_mul(sy, sp), sr));
        m.r_yz = q30_to_entry(round_mul(round_mul(cr, sy), sp) - round_mul(cy, sr));
        m.r_zx = q30_to_entry(-sp);
        m.r_zy = q30_to_entry(round_mul(cp, sr));
        m.r_zz = q30_to_entry(round_mul(cp, cr));
        return m;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int off;
        off = int'($urandom_range(64)) - 32;
        case ($urandom_range(9))
            0: return ANGLE_W'(12868 + off);
            1: return ANGLE_W'(-12868 + off);
            2: return ANGLE_W'((($urandom_range(1) != 0) ? 25736 : -25736) + off);
            3, 4: return ANGLE_W'(int'($urandom_range(1023)) - 512);
            default: return ANGLE_W'($urandom());
        endcase
    endfunction

    // idle about a quarter of the time, except inside the calm window
    function automatic bit take_break();
        if (cycle_cnt >= CALM_FIRST && cycle_cnt < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < 25;
    endfunction

    task automatic report_mismatch(input string what);
        err_cnt++;
        // cap the log; keep counting
        if (err_cnt <= MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endtask

    task automatic check_matrix(input euzyx_pkg::t_out_req got,
                                input euzyx_pkg::t_out_req want);
        logic signed [ENTRY_W-1:0] g;
        logic signed [ENTRY_W-1:0] w;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            g = got[(NUM_ENTRIES - 1 - k) * ENTRY_W +: ENTRY_W];
            w = want[(NUM_ENTRIES - 1 - k) * ENTRY_W +: ENTRY_W];
            if (g !== w) begin
                report_mismatch($sformatf("matrix %0d %s: got %0d expected %0d",
                                          results_seen, entry_name[k], g, w));
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (matrix_q.size() == 0) begin
                report_mismatch("matrix with no request pending");
            end else begin
                check_matrix(o_out_req, matrix_q.pop_front());
            end
            results_seen++;
        end
        i_out_ready <= !take_break();
    end

    initial begin
        euzyx_pkg::t_in_req  req;
        euzyx_pkg::t_out_req want;
        logic                fixed_want;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < NUM_DIRECTED + RANDOM_ITEMS; n++) begin
            if (n < NUM_DIRECTED) begin
                req        = DIRECTED[n].angles;
                fixed_want = DIRECTED[n].fixed_want;
                want       = DIRECTED[n].want;
            end else begin
                req.roll_angle  = rand_angle();
                req.pitch_angle = rand_angle();
                req.yaw_angle   = rand_angle();
                fixed_want      = 1'b0;
                want            = NONE;
            end
            while (take_break()) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_req   <= req;
            @(posedge i_clk);
            while (!o_in_ready) begin
                @(posedge i_clk);
            end
            matrix_q.push_back(fixed_want ? want : predict_matrix(req));
        end
        i_in_valid <= 1'b0;
        while (matrix_q.size() != 0) begin
            @(posedge i_clk);
        end
        // drain: catch any stray matrix behind the last one
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Checked %0d matrices from %0d directed and %0d random angle requests",
                 results_seen, NUM_DIRECTED, RANDOM_ITEMS);
        $display("Angles covered full code range, both half-pi fold edges and the half turn");
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
